// ===== hdl/nws_pkg.sv =====
package nws_pkg;

  typedef enum logic [2:0] {
    CFG_COUNT     = 3'd0,
    CFG_LIN_GAIN  = 3'd1,
    CFG_ANG_GAIN  = 3'd2,
    CFG_DONE_TH   = 3'd3,
    CFG_NEAR_TH   = 3'd4,
    CFG_MIN_SPEED = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_CMP,
    S_ROT,
    S_FLIP,
    S_VEC,
    S_LIN,
    S_ANG,
    S_OUT
  } state_e;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POSE = 1'b1;

  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
  localparam logic signed [23:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic [4:0]         CORDIC_LAST = 5'd19;
  localparam logic [4:0]         SQRT_LAST   = 5'd16;

  typedef struct packed {
    logic [4:0]  count;
    logic [15:0] lin_gain;
    logic [15:0] ang_gain;
    logic [15:0] done_th;
    logic [15:0] near_th;
    logic [15:0] min_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;
    logic [3:0]         target_index;
    logic               reached;
    logic               all_done;
  } res_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic mark;
  } tbl_ctl_t;

  function automatic logic signed [23:0] atan_q20(input logic [4:0] k);
    logic signed [23:0] a;
    unique case (k)
      5'd0:  a = 24'sd823550;
      5'd1:  a = 24'sd486170;
      5'd2:  a = 24'sd256879;
      5'd3:  a = 24'sd130396;
      5'd4:  a = 24'sd65451;
      5'd5:  a = 24'sd32757;
      5'd6:  a = 24'sd16383;
      5'd7:  a = 24'sd8192;
      5'd8:  a = 24'sd4096;
      5'd9:  a = 24'sd2048;
      5'd10: a = 24'sd1024;
      5'd11: a = 24'sd512;
      5'd12: a = 24'sd256;
      5'd13: a = 24'sd128;
      5'd14: a = 24'sd64;
      5'd15: a = 24'sd32;
      5'd16: a = 24'sd16;
      5'd17: a = 24'sd8;
      5'd18: a = 24'sd4;
      5'd19: a = 24'sd2;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/nws_if.sv =====
interface nws_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [3:0]         entry_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] heading;
  modport source (output valid, action, entry_index, pos_x, pos_y, heading, input ready);
  modport sink (input valid, action, entry_index, pos_x, pos_y, heading, output ready);
endinterface

interface nws_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_vel;
  logic signed [15:0] angular_vel;
  logic [3:0]         target_index;
  logic               reached;
  logic               all_done;
  modport source (output valid, linear_vel, angular_vel, target_index, reached, all_done,
                  input ready);
  modport sink (input valid, linear_vel, angular_vel, target_index, reached, all_done,
                output ready);
endinterface

interface nws_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/nws_table.sv =====
module nws_table #(
  parameter int MaxEntries = 16,
  parameter int AddrW      = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nws_pkg::tbl_ctl_t   ctl_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  logic [15:0]         wx_i,
  input  logic [15:0]         wy_i,
  input  logic [AddrW-1:0]    raddr_i,
  input  logic [AddrW-1:0]    maddr_i,
  output logic [15:0]         rx_o,
  output logic [15:0]         ry_o,
  output logic                vis_o
);

  logic [15:0]           mem_x [MaxEntries];
  logic [15:0]           mem_y [MaxEntries];
  logic [MaxEntries-1:0] vis_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_x[waddr_i] <= wx_i;
      mem_y[waddr_i] <= wy_i;
    end
    if (ctl_i.rd) begin
      rx_o <= mem_x[raddr_i];
      ry_o <= mem_y[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
    end else if (ctl_i.wr) begin
      vis_q[waddr_i] <= 1'b0;
    end else if (ctl_i.mark) begin
      vis_q[maddr_i] <= 1'b1;
    end
  end

  assign vis_o = vis_q[raddr_i];

endmodule

// ===== hdl/nws_core.sv =====
module nws_core #(
  parameter int MaxEntries = 16,
  parameter int AddrW      = 4,
  parameter int CntW       = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nws_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output nws_pkg::res_t      res_o
);

  nws_pkg::state_e state_q, state_d;

  logic [CntW-1:0]     i_q, cnt_q;
  logic [4:0]          k_q;
  logic signed [15:0]  px_q, py_q, th_q;
  logic signed [16:0]  dx_q, dy_q, bdx_q, bdy_q;
  logic [33:0]         sq_q, bit_q;
  logic [34:0]         r_q;
  logic [16:0]         bd_q;
  logic                bv_q, neg_q;
  logic [AddrW-1:0]    best_q;
  logic signed [35:0]  x_q, y_q;
  logic signed [23:0]  z_q;
  logic signed [31:0]  lin_q, ang_q;

  nws_pkg::tbl_ctl_t   ctl;
  logic [15:0]         rx, ry;
  logic                vis;
  logic [AddrW-1:0]    raddr;

  logic signed [24:0]  mul_a, mul_b;
  logic signed [49:0]  prod;
  logic [34:0]         sq_t;
  logic signed [35:0]  sx, sy, x_n, y_n, x0, y0;
  logic signed [23:0]  z_n, z0, atan;
  logic                plus;
  logic signed [16:0]  th_a, th_w;
  logic [8:0]          cnt_ext;
  logic                scan_end, load_ok, reached;
  logic signed [31:0]  lin_f, ang_f;

  nws_table #(.MaxEntries(MaxEntries), .AddrW(AddrW)) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .waddr_i (AddrW'(entry_index_i)),
    .wx_i    (pos_x_i),
    .wy_i    (pos_y_i),
    .raddr_i (raddr),
    .maddr_i (best_q),
    .rx_o    (rx),
    .ry_o    (ry),
    .vis_o   (vis)
  );

  assign scan_end = (i_q == cnt_q);
  assign raddr    = i_q[AddrW-1:0];
  assign load_ok  = (9'(entry_index_i) < 9'(MaxEntries));
  assign reached  = bv_q && (bd_q < {1'b0, cfg_i.done_th});
  assign cnt_ext  = (9'(cfg_i.count) > 9'(MaxEntries)) ? 9'(MaxEntries) : 9'(cfg_i.count);

  always_comb begin
    th_a = 17'(heading_i);
    if (th_a > nws_pkg::PI_Q12) begin
      th_a = th_a - nws_pkg::TWO_PI_Q12;
    end
    th_w = th_a;
    if (th_w < -nws_pkg::PI_Q12) begin
      th_w = th_w + nws_pkg::TWO_PI_Q12;
    end
  end

  always_comb begin
    unique case (state_q)
      nws_pkg::S_SQX: begin
        mul_a = 25'(dx_q);
        mul_b = 25'(dx_q);
      end
      nws_pkg::S_SQY: begin
        mul_a = 25'(dy_q);
        mul_b = 25'(dy_q);
      end
      nws_pkg::S_LIN: begin
        mul_a = {9'b0, cfg_i.lin_gain};
        mul_b = {8'b0, bd_q};
      end
      nws_pkg::S_ANG: begin
        mul_a = {9'b0, cfg_i.ang_gain};
        mul_b = 25'(z_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sq_t = r_q + {1'b0, bit_q};

  assign sx   = x_q >>> k_q;
  assign sy   = y_q >>> k_q;
  assign atan = nws_pkg::atan_q20(k_q);
  assign plus = (state_q == nws_pkg::S_ROT) ? !z_q[23] : !(y_q > 36'sd0);
  assign x_n  = plus ? x_q - sy : x_q + sy;
  assign y_n  = plus ? y_q + sx : y_q - sx;
  assign z_n  = plus ? z_q - atan : z_q + atan;

  assign x0 = {{7{bdx_q[16]}}, bdx_q, 12'b0};
  assign y0 = {{7{bdy_q[16]}}, bdy_q, 12'b0};
  assign z0 = -{th_q, 8'b0};

  assign lin_f = neg_q ? -lin_q : lin_q;
  assign ang_f = neg_q ? -ang_q : ang_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nws_pkg::S_IDLE: begin
        if (in_valid_i && action_i == nws_pkg::ACT_POSE) begin
          state_d = nws_pkg::S_SCAN;
        end
      end
      nws_pkg::S_SCAN: begin
        if (scan_end) begin
          if (!bv_q) begin
            state_d = nws_pkg::S_OUT;
          end else if (bd_q == '0) begin
            state_d = nws_pkg::S_LIN;
          end else begin
            state_d = nws_pkg::S_ROT;
          end
        end else if (!vis) begin
          state_d = nws_pkg::S_DIFF;
        end
      end
      nws_pkg::S_DIFF: state_d = nws_pkg::S_SQX;
      nws_pkg::S_SQX:  state_d = nws_pkg::S_SQY;
      nws_pkg::S_SQY:  state_d = nws_pkg::S_SQRT;
      nws_pkg::S_SQRT: begin
        if (k_q == nws_pkg::SQRT_LAST) begin
          state_d = nws_pkg::S_CMP;
        end
      end
      nws_pkg::S_CMP: state_d = nws_pkg::S_SCAN;
      nws_pkg::S_ROT: begin
        if (k_q == nws_pkg::CORDIC_LAST) begin
          state_d = nws_pkg::S_FLIP;
        end
      end
      nws_pkg::S_FLIP: state_d = nws_pkg::S_VEC;
      nws_pkg::S_VEC: begin
        if (k_q == nws_pkg::CORDIC_LAST) begin
          state_d = nws_pkg::S_LIN;
        end
      end
      nws_pkg::S_LIN: state_d = nws_pkg::S_ANG;
      nws_pkg::S_ANG: state_d = nws_pkg::S_OUT;
      nws_pkg::S_OUT: begin
        if (res_take_i) begin
          state_d = nws_pkg::S_IDLE;
        end
      end
      default: state_d = nws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == nws_pkg::S_IDLE);
    res_valid_o = (state_q == nws_pkg::S_OUT);
    ctl.wr   = in_ready_o && in_valid_i && action_i == nws_pkg::ACT_LOAD && load_ok;
    ctl.rd   = (state_q == nws_pkg::S_SCAN) && !scan_end && !vis;
    ctl.mark = res_valid_o && res_take_i && reached;
    if (bv_q) begin
      res_o.linear_vel   = nws_pkg::sat16(lin_f);
      res_o.angular_vel  = nws_pkg::sat16(ang_f);
      res_o.target_index = 4'(best_q);
      res_o.reached      = reached;
      res_o.all_done     = 1'b0;
    end else begin
      res_o.linear_vel   = '0;
      res_o.angular_vel  = '0;
      res_o.target_index = '0;
      res_o.reached      = 1'b0;
      res_o.all_done     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nws_pkg::S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      bv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        nws_pkg::S_IDLE: begin
          i_q  <= '0;
          bv_q <= 1'b0;
        end
        nws_pkg::S_SCAN: begin
          k_q <= '0;
          if (!scan_end && vis) begin
            i_q <= i_q + 1'b1;
          end
        end
        nws_pkg::S_SQY: k_q <= '0;
        nws_pkg::S_SQRT: k_q <= k_q + 1'b1;
        nws_pkg::S_CMP: begin
          i_q <= i_q + 1'b1;
          if (!bv_q || r_q[16:0] < bd_q) begin
            bv_q <= 1'b1;
          end
        end
        nws_pkg::S_ROT: k_q <= k_q + 1'b1;
        nws_pkg::S_FLIP: k_q <= '0;
        nws_pkg::S_VEC: k_q <= k_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nws_pkg::S_IDLE: begin
        px_q  <= pos_x_i;
        py_q  <= pos_y_i;
        th_q  <= th_w[15:0];
        cnt_q <= CntW'(cnt_ext);
      end
      nws_pkg::S_SCAN: begin
        neg_q <= 1'b0;
        if (scan_end && bd_q == '0) begin
          z_q <= '0;
          x_q <= x0;
          y_q <= y0;
        end else if (z0 > nws_pkg::HALF_PI_Q20) begin
          z_q <= z0 - nws_pkg::PI_Q20;
          x_q <= -x0;
          y_q <= -y0;
        end else if (z0 < -nws_pkg::HALF_PI_Q20) begin
          z_q <= z0 + nws_pkg::PI_Q20;
          x_q <= -x0;
          y_q <= -y0;
        end else begin
          z_q <= z0;
          x_q <= x0;
          y_q <= y0;
        end
      end
      nws_pkg::S_DIFF: begin
        dx_q <= {rx[15], rx} - {px_q[15], px_q};
        dy_q <= {ry[15], ry} - {py_q[15], py_q};
      end
      nws_pkg::S_SQX: sq_q <= prod[33:0];
      nws_pkg::S_SQY: begin
        sq_q  <= sq_q + prod[33:0];
        r_q   <= '0;
        bit_q <= 34'd1 << 32;
      end
      nws_pkg::S_SQRT: begin
        if ({1'b0, sq_q} >= sq_t) begin
          sq_q <= sq_q - sq_t[33:0];
          r_q  <= (r_q >> 1) + {1'b0, bit_q};
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      nws_pkg::S_CMP: begin
        if (!bv_q || r_q[16:0] < bd_q) begin
          bd_q   <= r_q[16:0];
          best_q <= i_q[AddrW-1:0];
          bdx_q  <= dx_q;
          bdy_q  <= dy_q;
        end
      end
      nws_pkg::S_ROT, nws_pkg::S_VEC: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
      end
      nws_pkg::S_FLIP: begin
        neg_q <= x_q[35];
        x_q   <= x_q[35] ? -x_q : x_q;
        z_q   <= '0;
      end
      nws_pkg::S_LIN: begin
        if (bd_q > {1'b0, cfg_i.near_th}) begin
          lin_q <= {7'b0, prod[32:8]};
        end else begin
          lin_q <= {16'b0, cfg_i.min_speed};
        end
      end
      nws_pkg::S_ANG: ang_q <= 32'(prod >>> 20);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nws_pkg::S_SCAN) |-> (i_q <= cnt_q))
    else $error("scan index passed the entry count");
  a_handoff_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_take_i) |=> (state_q == nws_pkg::S_IDLE))
    else $error("sequencer did not return to idle after handing off a result");
  a_flip_has_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nws_pkg::S_FLIP) |-> (bv_q && bd_q != '0))
    else $error("heading error computed without a target at nonzero distance");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.wr |-> (state_q == nws_pkg::S_IDLE))
    else $error("table written while a request is in work");
`endif

endmodule

// ===== hdl/nearest_waypoint_steering_top.sv =====
// Channel   Dir  Contents
// item_i    in   action, entry_index, pos_x, pos_y, heading
// result_o  out  linear_vel, angular_vel, target_index, reached, all_done
// cfg_i     in   index, data (register write, always ready)
// A load request writes the indexed table entry, if within range, and gives no result.
// A pose request scans the table, skipping visited entries and taking the distance of each
// unvisited one, then runs the CORDIC and scaling; all of it runs through one multiplier,
// one bit-serial square root step and one shift-add CORDIC stage under a sequencer.
// The result register lets the next request in while a result waits on result_o.ready.
// Reset clears the visited flags and loads the register defaults; goal entries stay unset.
module nearest_waypoint_steering_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nws_in_if.sink           item_i,
  nws_out_if.source        result_o,
  nws_cfg_if.sink          cfg_i
);

  localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW  = $clog2(MAX_ENTRIES + 1);

  nws_pkg::cfg_t cfg_q;
  nws_pkg::res_t res, out_q;
  logic          oval_q, res_valid, take;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count     <= 5'd0;
      cfg_q.lin_gain  <= 16'd384;
      cfg_q.ang_gain  <= 16'd5120;
      cfg_q.done_th   <= 16'd3;
      cfg_q.near_th   <= 16'd256;
      cfg_q.min_speed <= 16'd256;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        nws_pkg::CFG_COUNT:     cfg_q.count     <= cfg_i.data[4:0];
        nws_pkg::CFG_LIN_GAIN:  cfg_q.lin_gain  <= cfg_i.data;
        nws_pkg::CFG_ANG_GAIN:  cfg_q.ang_gain  <= cfg_i.data;
        nws_pkg::CFG_DONE_TH:   cfg_q.done_th   <= cfg_i.data;
        nws_pkg::CFG_NEAR_TH:   cfg_q.near_th   <= cfg_i.data;
        nws_pkg::CFG_MIN_SPEED: cfg_q.min_speed <= cfg_i.data;
        default: ;
      endcase
    end
  end

  nws_core #(.MaxEntries(MAX_ENTRIES), .AddrW(AddrW), .CntW(CntW)) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (item_i.valid),
    .in_ready_o    (item_i.ready),
    .action_i      (item_i.action),
    .entry_index_i (item_i.entry_index),
    .pos_x_i       (item_i.pos_x),
    .pos_y_i       (item_i.pos_y),
    .heading_i     (item_i.heading),
    .res_valid_o   (res_valid),
    .res_take_i    (take),
    .res_o         (res)
  );

  assign take = !oval_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (take) begin
      oval_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = oval_q;
  assign result_o.linear_vel   = out_q.linear_vel;
  assign result_o.angular_vel  = out_q.angular_vel;
  assign result_o.target_index = out_q.target_index;
  assign result_o.reached      = out_q.reached;
  assign result_o.all_done     = out_q.all_done;

endmodule

// ===== tb/testbench.sv =====
module testbench;

  localparam int LIMIT = 6000000;
  localparam int SETTLE = 600;
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam longint ATAN_Q20 [20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                       8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                                       4, 2};

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk = ~clk;

  nws_in_if  item_ch ();
  nws_out_if result_ch ();
  nws_cfg_if cfg_ch ();

  nearest_waypoint_steering_top dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .item_i  (item_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  logic signed [15:0] goal_x [16];
  logic signed [15:0] goal_y [16];
  bit                 visited [16];
  logic [4:0]         m_count;
  logic [15:0]        m_lin_gain, m_ang_gain, m_done_th, m_near_th, m_min_speed;

  nws_pkg::res_t expected_cmds [$];
  bit   stalls_on = 1'b1;
  int   errors = 0;
  int   cycles = 0;
  int   poses_sent = 0, loads_sent = 0, reached_seen = 0, all_done_seen = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint unsigned range_of(int i, longint px, longint py);
    longint ex, ey;
    ex = longint'(goal_x[i]) - px;
    ey = longint'(goal_y[i]) - py;
    return int_sqrt(longint'(ex * ex + ey * ey));
  endfunction

  function automatic nws_pkg::res_t steer_command(logic signed [15:0] px,
                                                  logic signed [15:0] py,
                                                  logic signed [15:0] hd);
    longint th, x, y, z, nx, err, lin, ang;
    longint unsigned d, bd;
    int best, cnt;
    bit neg;
    nws_pkg::res_t r;
    r = '0;
    best = -1;
    bd = 0;
    err = 0;
    neg = 1'b0;
    th = hd;
    if (th > nws_pkg::PI_Q12) th = th - nws_pkg::TWO_PI_Q12;
    if (th < -nws_pkg::PI_Q12) th = th + nws_pkg::TWO_PI_Q12;
    cnt = (m_count > 16) ? 16 : m_count;
    for (int i = 0; i < cnt; i++) begin
      if (!visited[i]) begin
        d = range_of(i, px, py);
        if (best < 0 || d < bd) begin
          best = i;
          bd = d;
        end
      end
    end
    if (best < 0) begin
      r.all_done = 1'b1;
      return r;
    end
    if (bd != 0) begin
      x = (longint'(goal_x[best]) - px) * 4096;
      y = (longint'(goal_y[best]) - py) * 4096;
      z = -th * 256;
      if (z > nws_pkg::HALF_PI_Q20) begin
        z = z - nws_pkg::PI_Q20; x = -x; y = -y;
      end else if (z < -nws_pkg::HALF_PI_Q20) begin
        z = z + nws_pkg::PI_Q20; x = -x; y = -y;
      end
      for (int k = 0; k < 20; k++) begin
        if (z >= 0) begin
          nx = x - (y >>> k); y = y + (x >>> k); z = z - ATAN_Q20[k];
        end else begin
          nx = x + (y >>> k); y = y - (x >>> k); z = z + ATAN_Q20[k];
        end
        x = nx;
      end
      neg = x < 0;
      if (x < 0) x = -x;
      z = 0;
      for (int k = 0; k < 20; k++) begin
        if (y > 0) begin
          nx = x + (y >>> k); y = y - (x >>> k); z = z + ATAN_Q20[k];
        end else begin
          nx = x - (y >>> k); y = y + (x >>> k); z = z - ATAN_Q20[k];
        end
        x = nx;
      end
      err = z;
    end
    if (bd > m_near_th) lin = (longint'(m_lin_gain) * longint'(bd)) >>> 8;
    else lin = m_min_speed;
    ang = (longint'(m_ang_gain) * err) >>> 20;
    if (neg) begin
      lin = -lin; ang = -ang;
    end
    r.linear_vel = clamp16(lin);
    r.angular_vel = clamp16(ang);
    r.target_index = best[3:0];
    r.reached = bd < m_done_th;
    if (r.reached) visited[best] = 1'b1;
    return r;
  endfunction

  task automatic send_request(logic act, logic [3:0] idx, logic signed [15:0] px,
                              logic signed [15:0] py, logic signed [15:0] hd);
    while (stalls_on && $urandom_range(99) < 18) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.entry_index <= idx;
    item_ch.pos_x <= px;
    item_ch.pos_y <= py;
    item_ch.heading <= hd;
    do @(posedge clk); while (!item_ch.ready);
    if (act == nws_pkg::ACT_POSE) begin
      expected_cmds.push_back(steer_command(px, py, hd));
      poses_sent++;
    end else begin
      goal_x[idx] = px;
      goal_y[idx] = py;
      visited[idx] = 1'b0;
      loads_sent++;
    end
  endtask

  task automatic drain;
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      nws_pkg::CFG_COUNT:     m_count = val[4:0];
      nws_pkg::CFG_LIN_GAIN:  m_lin_gain = val;
      nws_pkg::CFG_ANG_GAIN:  m_ang_gain = val;
      nws_pkg::CFG_DONE_TH:   m_done_th = val;
      nws_pkg::CFG_NEAR_TH:   m_near_th = val;
      nws_pkg::CFG_MIN_SPEED: m_min_speed = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(logic [4:0] cnt, logic [15:0] lg, logic [15:0] ag,
                         logic [15:0] dt, logic [15:0] nt, logic [15:0] ms);
    drain();
    write_reg(nws_pkg::CFG_COUNT, {11'd0, cnt});
    write_reg(nws_pkg::CFG_LIN_GAIN, lg);
    write_reg(nws_pkg::CFG_ANG_GAIN, ag);
    write_reg(nws_pkg::CFG_DONE_TH, dt);
    write_reg(nws_pkg::CFG_NEAR_TH, nt);
    write_reg(nws_pkg::CFG_MIN_SPEED, ms);
  endtask

  task automatic test_empty_table;
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_request(nws_pkg::ACT_POSE, 4'hF, 16'sh8000, 16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_table_load;
    for (int i = 0; i < 16; i++) begin
      send_request(nws_pkg::ACT_LOAD, i[3:0], 16'(i * 640 - 4000), 16'(3000 - i * 410),
                   16'($urandom));
    end
  endtask

  task automatic test_directed;
    set_all(5'd16, 16'd384, 16'd5120, 16'd3, 16'd256, 16'd256);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, 16'sh7FFF);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, 16'sh8000);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, 16'sd12869);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, -16'sd12869);
    send_request(nws_pkg::ACT_LOAD, 4'd2, 16'sd100, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_LOAD, 4'd3, 16'sd100, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd100, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd100, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd400, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd90, 16'sd100, 16'sd0);
    send_request(nws_pkg::ACT_LOAD, 4'd15, 16'sh7FFF, 16'sh7FFF, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sh8000, 16'sh8000, 16'sd6434);
    send_request(nws_pkg::ACT_LOAD, 4'd0, 16'sh8000, 16'sh8000, 16'sd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sh7FFF, 16'sh7FFF, 16'sd0);
    set_all(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, 16'sd3000);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd0, 16'sd0, -16'sd3000);
    set_all(5'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    send_request(nws_pkg::ACT_POSE, 4'd0, 16'sd5, 16'sd5, 16'sd0);
  endtask

  task automatic test_random_phases;
    int idx;
    for (int ph = 0; ph < 8; ph++) begin
      stalls_on = (ph != 3);
      set_all(ph == 0 ? 5'd16 : 5'($urandom_range(0, 20)),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8192)),
              16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64)),
              16'($urandom), 16'($urandom));
      for (int n = 0; n < 180; n++) begin
        idx = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0, 1: send_request(nws_pkg::ACT_LOAD, idx[3:0], 16'($urandom), 16'($urandom),
                             16'($urandom));
          2: send_request(nws_pkg::ACT_POSE, 4'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
          default: send_request(nws_pkg::ACT_POSE, 4'($urandom),
                                16'(goal_x[idx] + $urandom_range(0, 8) - 4),
                                16'(goal_y[idx] + $urandom_range(0, 8) - 4), 16'($urandom));
        endcase
      end
    end
    stalls_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_ni && result_ch.valid && result_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, result_ch.linear_vel);
          errors++;
        end else begin
          nws_pkg::res_t e;
          e = expected_cmds.pop_front();
          if (e.linear_vel !== result_ch.linear_vel) begin
            $display("%0t: linear_vel expected %0d actual %0d", $time, e.linear_vel,
                     result_ch.linear_vel);
            errors++;
          end
          if (e.angular_vel !== result_ch.angular_vel) begin
            $display("%0t: angular_vel expected %0d actual %0d", $time, e.angular_vel,
                     result_ch.angular_vel);
            errors++;
          end
          if (e.target_index !== result_ch.target_index) begin
            $display("%0t: target_index expected %0d actual %0d", $time, e.target_index,
                     result_ch.target_index);
            errors++;
          end
          if (e.reached !== result_ch.reached) begin
            $display("%0t: reached expected %0d actual %0d", $time, e.reached,
                     result_ch.reached);
            errors++;
          end
          if (e.all_done !== result_ch.all_done) begin
            $display("%0t: all_done expected %0d actual %0d", $time, e.all_done,
                     result_ch.all_done);
            errors++;
          end
          reached_seen += e.reached;
          all_done_seen += e.all_done;
        end
      end
      result_ch.ready <= !(stalls_on && $urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.action = nws_pkg::ACT_LOAD;
    item_ch.entry_index = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.heading = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = nws_pkg::CFG_COUNT;
    cfg_ch.data = '0;
    m_count = 5'd0;
    m_lin_gain = 16'd384;
    m_ang_gain = 16'd5120;
    m_done_th = 16'd3;
    m_near_th = 16'd256;
    m_min_speed = 16'd256;
    foreach (visited[i]) visited[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_table_load();
    test_directed();
    test_random_phases();
    drain();
    $display("Sent %0d pose and %0d load requests over 11 written register settings.",
             poses_sent, loads_sent);
    $display("Checkpoints reached: %0d, all-done stops: %0d.", reached_seen, all_done_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/nws_pkg.sv
hdl/nws_if.sv
hdl/nws_table.sv
hdl/nws_core.sv
hdl/nearest_waypoint_steering_top.sv
tb/testbench.sv
